// File: src/text_to_integer_any_base_top_defines.svh
// Assertion macros used by the checker file.
`ifndef TEXT_TO_INTEGER_ANY_BASE_TOP_DEFINES_SVH
`define TEXT_TO_INTEGER_ANY_BASE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TIAB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text_to_integer_any_base: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define TIAB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text_to_integer_any_base: next-cycle check failed");

`endif

// File: src/tiab_pkg.sv
`timescale 1ns / 1ps
package tiab_pkg;

  localparam int CHAR_W    = 8;
  localparam int VALUE_W   = 32;
  localparam int BASE_W    = 5;
  localparam int DIGIT_W   = 4;
  localparam int INDEX_W   = 2;
  localparam int CFG_W     = 64;
  localparam int ALPHA_MAX = 16;

  localparam logic [BASE_W-1:0] LENGTH_RESET = BASE_W'(10);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_ALPHABET_LOW    = 2'd0,
    REG_ALPHABET_HIGH   = 2'd1,
    REG_ALPHABET_LENGTH = 2'd2
  } reg_index_t;

  // One classified character word, as handed from the front to the back.
  typedef struct packed {
    logic                last;
    logic                is_space;
    logic                is_plus;
    logic                is_minus;
    logic                found;
    logic [DIGIT_W-1:0]  digit;
    logic [BASE_W-1:0]   base;
  } class_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return c inside {CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR, CH_SPACE};
  endfunction

endpackage

// File: src/tiab_front.sv
`timescale 1ns / 1ps
module tiab_front #(
  parameter int MAX_ALPHABET = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [tiab_pkg::INDEX_W-1:0] write_index,
  input  logic [tiab_pkg::CFG_W-1:0]   write_data,
  input  logic [tiab_pkg::CHAR_W-1:0]  character,
  input  logic                         last_char,
  output tiab_pkg::class_t             cls,
  output logic                         bad
);
  import tiab_pkg::*;

  logic [CFG_W-1:0]  alphabet_low;
  logic [CFG_W-1:0]  alphabet_high;
  logic [BASE_W-1:0] alphabet_length;
  logic [2*CFG_W-1:0] alphabet_all;
  logic [CHAR_W-1:0] sym [MAX_ALPHABET];
  logic [MAX_ALPHABET-1:0] in_use;
  logic [BASE_W-1:0] eff_len;
  logic              bad_next;
  logic              found;
  logic [DIGIT_W-1:0] digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low    <= '0;
      alphabet_high   <= '0;
      alphabet_length <= LENGTH_RESET;
    end else if (write_enable) begin
      case (write_index)
        REG_ALPHABET_LOW:    alphabet_low    <= write_data;
        REG_ALPHABET_HIGH:   alphabet_high   <= write_data;
        REG_ALPHABET_LENGTH: alphabet_length <= write_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign alphabet_all = {alphabet_high, alphabet_low};

  for (genvar k = 0; k < MAX_ALPHABET; k++) begin : g_sym
    assign sym[k]    = alphabet_all[k*CHAR_W +: CHAR_W];
    assign in_use[k] = BASE_W'(k) < eff_len;
  end

  // The base is the length clipped to the lane count, cut short at the first zero byte.
  always_comb begin
    logic [BASE_W-1:0] n_sat;
    n_sat = (alphabet_length > BASE_W'(MAX_ALPHABET)) ? BASE_W'(MAX_ALPHABET)
                                                      : alphabet_length;
    eff_len = n_sat;
    for (int k = MAX_ALPHABET - 1; k >= 0; k--) begin
      if ((BASE_W'(k) < n_sat) && (sym[k] == CH_NUL)) begin
        eff_len = BASE_W'(k);
      end
    end
  end

  always_comb begin
    found = 1'b0;
    digit = '0;
    for (int k = 0; k < MAX_ALPHABET; k++) begin
      if (!found && in_use[k] && (character != CH_NUL) && (sym[k] == character)) begin
        found = 1'b1;
        digit = DIGIT_W'(k);
      end
    end
  end

  always_comb begin
    bad_next = 1'b0;
    for (int i = 0; i < MAX_ALPHABET; i++) begin
      if (in_use[i]) begin
        if (is_space(sym[i]) || (sym[i] == CH_PLUS) || (sym[i] == CH_MINUS)) begin
          bad_next = 1'b1;
        end
        for (int j = i + 1; j < MAX_ALPHABET; j++) begin
          if (in_use[j] && (sym[j] == sym[i])) begin
            bad_next = 1'b1;
          end
        end
      end
    end
  end

  // Not enforced here; the user must ensure the back reads this only for words accepted after the write has settled.
  always_ff @(posedge clk) begin
    if (rst) begin
      bad <= 1'b0;
    end else begin
      bad <= bad_next;
    end
  end

  always_comb begin
    cls.last     = last_char;
    cls.is_space = is_space(character);
    cls.is_plus  = (character == CH_PLUS);
    cls.is_minus = (character == CH_MINUS);
    cls.found    = found;
    cls.digit    = digit;
    cls.base     = eff_len;
  end

endmodule

// File: src/tiab_queue.sv
`timescale 1ns / 1ps
module tiab_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tiab_pkg::class_t din,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output tiab_pkg::class_t dout
);
  import tiab_pkg::*;

  class_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: src/tiab_back.sv
`timescale 1ns / 1ps
module tiab_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              valid,
  input  tiab_pkg::class_t                  cls,
  output logic                              take,
  input  logic                              bad_cfg,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [tiab_pkg::VALUE_W-1:0] value,
  output logic                              bad_alphabet
);
  import tiab_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  logic                 negative;
  logic                 negative_next;
  logic [VALUE_W-1:0]   accumulator;
  logic [VALUE_W-1:0]   accumulator_next;
  logic [VALUE_W-1:0]   product;
  logic [VALUE_W-1:0]   result;

  logic [VALUE_W-1:0]   out_value [2];
  logic                 out_bad   [2];
  logic                 out_wr;
  logic                 out_rd;
  logic [1:0]           out_count;
  logic                 out_push;
  logic                 out_pop;

  // A closing word needs room in the result queue; any other word always goes.
  assign take     = valid && (!cls.last || (out_count != 2'd2));
  assign out_push = take && cls.last;
  assign out_pop  = pop && !empty;
  assign product  = accumulator * VALUE_W'(cls.base);

  always_comb begin
    phase_t ph;
    logic [VALUE_W-1:0] acc;
    ph            = phase;
    negative_next = negative;
    acc           = accumulator;
    if ((ph == PH_SPACE) && !cls.is_space) begin
      ph = PH_SIGN;
    end
    if (ph == PH_SIGN) begin
      if (cls.is_minus) begin
        negative_next = ~negative;
      end else if (!cls.is_plus) begin
        ph = PH_DIGIT;
      end
    end
    if (ph == PH_DIGIT) begin
      if (cls.found) begin
        acc = product + VALUE_W'(cls.digit);
      end else begin
        ph = PH_DONE;
      end
    end
    if (bad_cfg) begin
      result = '0;
    end else if (negative_next) begin
      result = '0 - acc;
    end else begin
      result = acc;
    end
    if (cls.last) begin
      phase_next       = PH_SPACE;
      negative_next    = 1'b0;
      accumulator_next = '0;
    end else begin
      phase_next       = ph;
      accumulator_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      negative    <= 1'b0;
      accumulator <= '0;
    end else if (take) begin
      phase       <= phase_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_value[out_wr] <= result;
      out_bad[out_wr]   <= bad_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= 1'b0;
      out_rd    <= 1'b0;
      out_count <= 2'd0;
    end else begin
      if (out_push) begin
        out_wr <= ~out_wr;
      end
      if (out_pop) begin
        out_rd <= ~out_rd;
      end
      if (out_push && !out_pop) begin
        out_count <= out_count + 2'd1;
      end else if (out_pop && !out_push) begin
        out_count <= out_count - 2'd1;
      end
    end
  end

  assign empty        = (out_count == 2'd0);
  assign value        = $signed(out_value[out_rd]);
  assign bad_alphabet = out_bad[out_rd];

endmodule

// File: src/text_to_integer_any_base_top.sv
`timescale 1ns / 1ps
// Streaming text-to-integer converter with a programmable digit alphabet. One character
// word is taken per clock cycle while the input queue is not full; a string's last character
// is registered into the input queue and its result into the result queue when the back takes it. That
// rate is set by the back end, which does one multiply-add of the 32-bit
// accumulator by the base per cycle, while the front end compares each character against
// all alphabet lanes in parallel. A two-word queue sits between front and back, and a
// two-word result queue at the output, so push and pop may stall independently. Write
// the alphabet registers only while no string is in flight; an alphabet with whitespace,
// a sign or a repeated character yields value 0 with bad_alphabet set.
module text_to_integer_any_base_top #(
  parameter int MAX_ALPHABET = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic [tiab_pkg::CHAR_W-1:0]          character,
  input  logic                                 last_char,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [tiab_pkg::VALUE_W-1:0]  value,
  output logic                                 bad_alphabet,
  input  logic                                 write_enable,
  input  logic [tiab_pkg::INDEX_W-1:0]         write_index,
  input  logic [tiab_pkg::CFG_W-1:0]           write_data
);
  import tiab_pkg::*;

  class_t front_cls;
  class_t back_cls;
  logic   bad_cfg;
  logic   q_valid;
  logic   q_take;

  tiab_front #(
    .MAX_ALPHABET(MAX_ALPHABET)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .write_index (write_index),
    .write_data  (write_data),
    .character   (character),
    .last_char   (last_char),
    .cls         (front_cls),
    .bad         (bad_cfg)
  );

  tiab_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_cls),
    .full (full),
    .valid(q_valid),
    .pop  (q_take),
    .dout (back_cls)
  );

  tiab_back u_back (
    .clk         (clk),
    .rst         (rst),
    .valid       (q_valid),
    .cls         (back_cls),
    .take        (q_take),
    .bad_cfg     (bad_cfg),
    .empty       (empty),
    .pop         (pop),
    .value       (value),
    .bad_alphabet(bad_alphabet)
  );

endmodule

// File: src/tiab_checker.sv
`timescale 1ns / 1ps
`include "text_to_integer_any_base_top_defines.svh"
module tiab_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                push,
  input logic                                full,
  input logic                                last_char,
  input logic                                empty,
  input logic                                pop,
  input logic signed [tiab_pkg::VALUE_W-1:0] value,
  input logic                                bad_alphabet
);
  import tiab_pkg::*;

  // Strings whose last word went in and whose result has not yet been taken.
  logic [2:0] pending;
  logic       closes;
  logic       takes;

  assign closes = push && !full && last_char;
  assign takes  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else if (closes && !takes) begin
      pending <= pending + 3'd1;
    end else if (takes && !closes) begin
      pending <= pending - 3'd1;
    end
  end

  `TIAB_ASSERT_IMP(no_result_without_string, clk, rst, pending == 3'd0, empty)
  `TIAB_ASSERT_IMP(bad_alphabet_gives_zero, clk, rst, !empty && bad_alphabet, value == '0)
  `TIAB_ASSERT_NXT(stalled_result_holds, clk, rst, !empty && !pop, $stable(value) && $stable(bad_alphabet))

endmodule

bind text_to_integer_any_base_top tiab_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .last_char   (last_char),
  .empty       (empty),
  .pop         (pop),
  .value       (value),
  .bad_alphabet(bad_alphabet)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import tiab_pkg::*;

  localparam int GAP_MAX = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [CHAR_W-1:0] BLANKS [6] = '{CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR, CH_SPACE};

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      bad;
  } result_t;

  // Tracks the parser state and alphabet, and holds the words still owed by the block.
  class atoi_scoreboard;
    logic [CFG_W-1:0]   alpha_lo;
    logic [CFG_W-1:0]   alpha_hi;
    logic [BASE_W-1:0]  alpha_len;
    phase_t             ph;
    logic               negative;
    logic [VALUE_W-1:0] acc;
    result_t            waiting[$];
    int                 mismatches;

    function new();
      alpha_lo = '0;
      alpha_hi = '0;
      alpha_len = LENGTH_RESET;
      ph = PH_SPACE;
      negative = 1'b0;
      acc = '0;
      mismatches = 0;
    endfunction

    static function bit is_blank(logic [CHAR_W-1:0] c);
      return c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF || c == CH_CR ||
             c == CH_SPACE;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ALPHABET_LOW: alpha_lo = data;
        REG_ALPHABET_HIGH: alpha_hi = data;
        REG_ALPHABET_LENGTH: alpha_len = data[BASE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] symbol(int k);
      return (k < 8) ? alpha_lo[k*8 +: 8] : alpha_hi[(k-8)*8 +: 8];
    endfunction

    // The base ends at the first zero byte within the programmed length.
    function int base();
      int n;
      n = alpha_len;
      if (n > ALPHA_MAX) n = ALPHA_MAX;
      for (int k = 0; k < n; k++)
        if (symbol(k) == CH_NUL) return k;
      return n;
    endfunction

    function bit invalid();
      int n;
      logic [CHAR_W-1:0] c;
      n = base();
      for (int i = 0; i < n; i++) begin
        c = symbol(i);
        if (is_blank(c) || c == CH_PLUS || c == CH_MINUS) return 1'b1;
        for (int j = i + 1; j < n; j++)
          if (symbol(j) == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_char(logic [CHAR_W-1:0] c, logic last);
      int n;
      bit found;
      result_t r;
      if (ph == PH_SPACE && !is_blank(c)) ph = PH_SIGN;
      if (ph == PH_SIGN) begin
        if (c == CH_MINUS) negative = ~negative;
        else if (c != CH_PLUS) ph = PH_DIGIT;
      end
      if (ph == PH_DIGIT) begin
        n = base();
        found = 1'b0;
        if (c != CH_NUL) begin
          for (int k = 0; k < n && !found; k++) begin
            if (symbol(k) == c) begin
              acc = acc * VALUE_W'(n) + VALUE_W'(k);
              found = 1'b1;
            end
          end
        end
        if (!found) ph = PH_DONE;
      end
      if (last) begin
        r.bad = invalid();
        r.value = r.bad ? '0 : (negative ? -acc : acc);
        waiting.push_back(r);
        ph = PH_SPACE;
        negative = 1'b0;
        acc = '0;
      end
    endfunction

    function void check_word(logic signed [VALUE_W-1:0] v, logic bad);
      result_t e;
      if (waiting.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %0d bad_alphabet %0b", v, bad);
      end else begin
        e = waiting.pop_front();
        if (v !== e.value || bad !== e.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d bad_alphabet %0b, got value %0d bad_alphabet %0b",
                     e.value, e.bad, v, bad);
        end
      end
    endfunction

    function int pending();
      return waiting.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      push;
  logic                      full;
  logic [CHAR_W-1:0]         character;
  logic                      last_char;
  logic                      empty;
  logic                      pop;
  logic signed [VALUE_W-1:0] value;
  logic                      bad_alphabet;
  logic                      write_enable;
  logic [INDEX_W-1:0]        write_index;
  logic [CFG_W-1:0]          write_data;

  atoi_scoreboard    sb;
  logic [CHAR_W-1:0] text[$];
  bit                send_steady;
  bit                reader_hold;
  int                stall_count = 0;

  text_to_integer_any_base_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || write_enable) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin : reader
    int gap;
    int served;
    bit steady;
    served = 0;
    steady = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (reader_hold) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        reader_hold = 1'b0;
      end
      if (served % 20 == 0) steady = ($urandom_range(0, 2) == 0);
      gap = steady ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_word(value, bad_alphabet);
      served++;
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] c, logic last);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    character <= c;
    last_char <= last;
    do @(posedge clk); while (full);
    sb.take_char(c, last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  function automatic void append(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic logic [2*CFG_W-1:0] pack(string s);
    logic [2*CFG_W-1:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < ALPHA_MAX; i++) r[i*8 +: 8] = s[i];
    return r;
  endfunction

  // Waits until every owed word is out, then lets the pipeline go quiet.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_alphabet(logic [2*CFG_W-1:0] chars, logic [BASE_W-1:0] len);
    drain();
    set_reg(REG_ALPHABET_LOW, chars[CFG_W-1:0]);
    set_reg(REG_ALPHABET_HIGH, chars[2*CFG_W-1:CFG_W]);
    // Bits above the length field are don't-care and get random values.
    set_reg(REG_ALPHABET_LENGTH, {$urandom, 27'($urandom), len});
  endtask

  task automatic load_random_alphabet();
    bit used [256];
    logic [2*CFG_W-1:0] chars;
    logic [CHAR_W-1:0] c;
    int k;
    chars = '0;
    k = 0;
    while (k < ALPHA_MAX) begin
      c = CHAR_W'($urandom_range(1, 255));
      if (!used[c] && !atoi_scoreboard::is_blank(c) && c != CH_PLUS && c != CH_MINUS) begin
        used[c] = 1'b1;
        chars[k*8 +: 8] = c;
        k++;
      end
    end
    load_alphabet(chars, BASE_W'($urandom_range(2, ALPHA_MAX)));
  endtask

  // Mostly well-formed numbers in the current alphabet, with some plain noise.
  function automatic void make_string();
    int n;
    int count;
    n = sb.base();
    if ($urandom_range(0, 9) == 0) begin
      count = $urandom_range(1, 6);
      repeat (count) text.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) text.push_back(BLANKS[$urandom_range(0, 5)]);
      count = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (count) text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
      repeat (count)
        text.push_back(n > 0 ? sb.symbol($urandom_range(0, n - 1))
                             : CHAR_W'($urandom_range(0, 255)));
      case ($urandom_range(0, 3))
        0: text.push_back(CH_NUL);
        1: text.push_back(CHAR_W'($urandom_range(0, 255)));
        default: ;
      endcase
      repeat ($urandom_range(0, 2)) text.push_back(CHAR_W'($urandom_range(0, 255)));
    end
    if (text.size() == 0) text.push_back(CHAR_W'($urandom_range(0, 255)));
  endfunction

  task automatic run_strings(int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      send_steady = ($urandom_range(0, 4) == 0);
      make_string();
      sent += text.size();
      send_text();
    end
  endtask

  initial begin
    push = 1'b0;
    character = '0;
    last_char = 1'b0;
    pop = 1'b0;
    write_enable = 1'b0;
    write_index = '0;
    write_data = '0;
    rst = 1'b1;
    reader_hold = 1'b0;
    send_steady = 1'b0;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the alphabet is all zero bytes, so no character is a digit.
    append("-7");
    send_text();
    load_alphabet(pack("0123456789"), 5'd10);
    foreach (BLANKS[i]) text.push_back(BLANKS[i]);
    append("-+-42");
    send_text();
    append("-9");
    send_text();
    append("7");
    text.push_back(CH_NUL);
    append("9");
    send_text();
    text.push_back(8'hFF);
    send_text();
    append("12x34");
    send_text();
    text.push_back(CH_SPACE);
    send_text();

    // The reader stops for a while so that both queues fill and push stalls.
    reader_hold = 1'b1;
    run_strings(100);

    load_alphabet(pack("0123456789ABCDEF"), 5'd16);
    run_strings(80);
    load_alphabet(pack("0123456789abcdef"), 5'd31);
    run_strings(40);
    load_alphabet(pack("0123456789"), 5'd0);
    run_strings(30);
    load_alphabet(pack("0"), 5'd1);
    run_strings(30);
    load_alphabet(pack("01234") | (pack("6789") << 48), 5'd12);
    run_strings(50);

    load_alphabet(pack("01 3"), 5'd4);
    run_strings(20);
    load_alphabet(pack("01+3"), 5'd4);
    run_strings(20);
    load_alphabet(pack("0-23"), 5'd4);
    run_strings(20);
    load_alphabet(pack("01\v23"), 5'd5);
    run_strings(20);
    load_alphabet(pack("01231"), 5'd5);
    run_strings(20);
    // A blank just past the length in use does not spoil the alphabet.
    load_alphabet(pack("0123 "), 5'd4);
    run_strings(20);
    load_alphabet({2*CFG_W{1'b1}}, 5'd8);
    run_strings(20);

    drain();
    set_reg(REG_SPARE, {$urandom, $urandom});
    run_strings(20);

    repeat (4) begin
      load_random_alphabet();
      run_strings(20);
    end
    repeat (4) begin
      load_alphabet({$urandom, $urandom, $urandom, $urandom}, BASE_W'($urandom_range(0, 31)));
      run_strings(20);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
